[src/spot_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants for the shape pair overlap test.
// No dependencies; every other file imports this package.
package spot_pkg;

   // coordinate and field widths
   localparam int COORD_WIDTH = 24;
   localparam int SIZE_W      = COORD_WIDTH - 1;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int TURN_W      = 13;

   // stream packing, first field in the lowest bits
   localparam int OFF_A_PX   = 0;
   localparam int OFF_A_PY   = OFF_A_PX + COORD_WIDTH;
   localparam int OFF_A_SX   = OFF_A_PY + COORD_WIDTH;
   localparam int OFF_A_SY   = OFF_A_SX + SIZE_W;
   localparam int OFF_A_TURN = OFF_A_SY + SIZE_W;
   localparam int OFF_B_PX   = OFF_A_TURN + TURN_W;
   localparam int OFF_B_PY   = OFF_B_PX + COORD_WIDTH;
   localparam int OFF_B_SX   = OFF_B_PY + COORD_WIDTH;
   localparam int OFF_B_SY   = OFF_B_SX + SIZE_W;
   localparam int OFF_B_TURN = OFF_B_SY + SIZE_W;
   localparam int REQ_BITS   = OFF_B_TURN + TURN_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int OP_W       = 3;
   localparam int RSP_DATA_W = 8;

   // angle to binary phase: floor(t * 2^32 / ANGLE_STEPS)
   localparam int ANGLE_STEPS = 5760;
   localparam int PHASE_W     = 32;
   localparam longint unsigned PHASE_FULL = 64'd1 << PHASE_W;
   localparam longint unsigned PHASE_MUL  = PHASE_FULL / ANGLE_STEPS;
   localparam longint unsigned PHASE_REM  = PHASE_FULL - PHASE_MUL * ANGLE_STEPS;
   localparam int RECIP_SHIFT = TURN_W + 2 * $clog2(ANGLE_STEPS);
   localparam longint unsigned PHASE_RECIP =
      ((64'd1 << RECIP_SHIFT) + ANGLE_STEPS - 1) / ANGLE_STEPS;
   localparam longint unsigned PHASE_RM = PHASE_REM * PHASE_RECIP;

   // CORDIC
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam int CX_W         = 34;
   localparam int CZ_W         = PHASE_W + 1;
   localparam int TRIG_W       = 31;
   localparam int TRIG_FRAC    = 28;
   localparam int MAG_W        = TRIG_W - 1;
   localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);

   localparam logic [PHASE_W-1:0] ATAN_PHASE [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // item line ahead of the test stages: input, phase, phase register, CORDIC
   localparam int LINE_LEN = 3 + CORDIC_LAT;

   // test datapath widths
   localparam int PROD_W  = DIFF_W + TRIG_W;
   localparam int FRAME_W = PROD_W + 1;
   localparam int KP_W    = MAG_W + SIZE_W;
   localparam int SAT_W   = FRAME_W + 1;
   localparam int RF_W    = FRAME_W - TRIG_FRAC;
   localparam int AX_W    = RF_W + 1;
   localparam int LIM_W   = SIZE_W + 1;
   localparam int TEST_STAGES = 7;
   localparam logic signed [FRAME_W-1:0] HALF_LSB = FRAME_W'(1) << (TRIG_FRAC - 1);

   typedef enum logic [OP_W-1:0] {
      OP_PT_CIRC   = 3'd0,
      OP_PT_RECT   = 3'd1,
      OP_CIRC_CIRC = 3'd2,
      OP_CIRC_RECT = 3'd3,
      OP_RECT_RECT = 3'd4
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [SIZE_W-1:0]        aw;
      logic [SIZE_W-1:0]        ah;
      logic [SIZE_W-1:0]        bw;
      logic [SIZE_W-1:0]        bh;
      logic                     same_turn;
      logic                     a_zero;
      logic                     b_zero;
   } item_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
   } trig_type;

endpackage

[src/shape_pair_overlap_test.sv]
`timescale 1ns / 1ps
// Top level of the shape pair overlap test: input decode, item line, skid output.
// Depends on spot_pkg, spot_phase, spot_cordic and spot_test.
//
// Takes one shape pair per clock while req_tready is high and answers one hit
// flag per pair, in order. Each item passes through a fixed pipeline of 42
// register stages (turn to phase, a 30-step CORDIC run for both angles and their
// difference, frame rotation, separating-axis sums, squares and compares). The
// pipeline feeds a two-item output buffer, which registers each hit flag and
// offers it on rsp: req_tready drops only while the buffer holds two results,
// and then the whole pipeline holds in place. Throughput is one item per cycle
// while req_tready is high.
module shape_pair_overlap_test (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // a_pos_x, a_pos_y, a_size_x, a_size_y, a_turn,
   // b_pos_x, b_pos_y, b_size_x, b_size_y, b_turn, zero fill
   input  logic [spot_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [spot_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit, zero fill
   output logic [spot_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import spot_pkg::*;

   logic en, push, pop;
   logic [1:0] cnt_ff, cnt_in;
   logic head_ff, tail_ff, head_in, tail_in;

   logic [LINE_LEN-1:0] line_v_ff;
   item_type            line_ff [LINE_LEN];
   item_type            item_in;
   item_type            mark_in;

   logic [PHASE_W-1:0] pa_t2, pb_t2;
   logic [PHASE_W-1:0] pa_ff, pb_ff, pd_ff;
   trig_type           trig_a, trig_b, trig_d;
   logic               t_valid, t_hit;

   logic signed [COORD_WIDTH-1:0] apx, apy, bpx, bpy;

   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   always_comb begin
      apx = req_tdata[OFF_A_PX +: COORD_WIDTH];
      apy = req_tdata[OFF_A_PY +: COORD_WIDTH];
      bpx = req_tdata[OFF_B_PX +: COORD_WIDTH];
      bpy = req_tdata[OFF_B_PY +: COORD_WIDTH];
      item_in.op        = req_tuser;
      item_in.dx        = {apx[COORD_WIDTH-1], apx} - {bpx[COORD_WIDTH-1], bpx};
      item_in.dy        = {apy[COORD_WIDTH-1], apy} - {bpy[COORD_WIDTH-1], bpy};
      item_in.aw        = req_tdata[OFF_A_SX +: SIZE_W];
      item_in.ah        = req_tdata[OFF_A_SY +: SIZE_W];
      item_in.bw        = req_tdata[OFF_B_SX +: SIZE_W];
      item_in.bh        = req_tdata[OFF_B_SY +: SIZE_W];
      item_in.same_turn = 1'b0;
      item_in.a_zero    = 1'b0;
      item_in.b_zero    = 1'b0;
   end

   spot_phase u_phase_a (
      .clock (clock),
      .en    (en),
      .turn  (req_tdata[OFF_A_TURN +: TURN_W]),
      .phase (pa_t2)
   );

   spot_phase u_phase_b (
      .clock (clock),
      .en    (en),
      .turn  (req_tdata[OFF_B_TURN +: TURN_W]),
      .phase (pb_t2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         line_v_ff <= '0;
      end else if (en) begin
         line_v_ff <= {line_v_ff[LINE_LEN-2:0], req_tvalid};
      end
   end

   // phases rise strictly in the folded turn: equal phases, equal turns mod 5760
   always_comb begin
      mark_in           = line_ff[1];
      mark_in.same_turn = (pa_t2 == pb_t2);
      mark_in.a_zero    = (pa_t2 == '0);
      mark_in.b_zero    = (pb_t2 == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= item_in;
         line_ff[1] <= line_ff[0];
         line_ff[2] <= mark_in;
         for (int i = 3; i < LINE_LEN; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
         pa_ff <= pa_t2;
         pb_ff <= pb_t2;
         pd_ff <= pa_t2 - pb_t2;
      end
   end

   spot_cordic u_cordic_a (.clock(clock), .en(en), .phase(pa_ff), .trig(trig_a));
   spot_cordic u_cordic_b (.clock(clock), .en(en), .phase(pb_ff), .trig(trig_b));
   spot_cordic u_cordic_d (.clock(clock), .en(en), .phase(pd_ff), .trig(trig_d));

   spot_test u_test (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (line_v_ff[LINE_LEN-1]),
      .item      (line_ff[LINE_LEN-1]),
      .trig_a    (trig_a),
      .trig_b    (trig_b),
      .trig_d    (trig_d),
      .out_valid (t_valid),
      .hit       (t_hit)
   );

   // two-item output buffer
   assign push = en && t_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      if (push && pop) begin
         if (cnt_ff == 2'd1) begin
            head_in = t_hit;
         end else begin
            head_in = tail_ff;
            tail_in = t_hit;
         end
      end else if (push) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd0) begin
            head_in = t_hit;
         end else begin
            tail_in = t_hit;
         end
      end else if (pop) begin
         cnt_in  = cnt_ff - 2'd1;
         head_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, head_ff};

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> (cnt_ff == 2'd2))
      else $error("output buffer took an item while full");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> line_v_ff[0])
      else $error("accepted item did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(line_v_ff) && (t_valid == $past(t_valid)))
      else $error("pipeline moved during a stall");

endmodule

[src/spot_phase.sv]
`timescale 1ns / 1ps
// Turn to binary phase converter, two register stages.
// Depends on spot_pkg.
module spot_phase (
   input  logic                         clock,
   input  logic                         en,
   input  logic [spot_pkg::TURN_W-1:0]  turn,
   output logic [spot_pkg::PHASE_W-1:0] phase
);
   import spot_pkg::*;

   logic [TURN_W-1:0]  tm_ff, tm_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   // one subtract folds a turn that wraps past a full circle
   always_comb begin
      tm_in = (turn >= TURN_W'(ANGLE_STEPS)) ? turn - TURN_W'(ANGLE_STEPS) : turn;
      phase_in = PHASE_W'(64'(tm_ff) * PHASE_MUL)
               + PHASE_W'((64'(tm_ff) * PHASE_RM) >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tm_ff    <= tm_in;
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

[src/spot_cordic.sv]
`timescale 1ns / 1ps
// Pipelined rotation CORDIC: phase in, cosine and sine out in Q.28.
// Depends on spot_pkg.
module spot_cordic (
   input  logic                         clock,
   input  logic                         en,
   input  logic [spot_pkg::PHASE_W-1:0] phase,
   output spot_pkg::trig_type           trig
);
   import spot_pkg::*;

   logic [1:0]             quad_ff [CORDIC_STEPS+1];
   logic signed [CX_W-1:0] x_ff    [CORDIC_STEPS+1];
   logic signed [CX_W-1:0] y_ff    [CORDIC_STEPS+1];
   logic signed [CZ_W-1:0] z_ff    [CORDIC_STEPS+1];
   trig_type               trig_ff, trig_in;

   logic [PHASE_W-1:0]     phase_off, resid;
   logic [1:0]             quad_in;
   logic signed [CX_W-1:0] xr_full, yr_full;
   logic signed [TRIG_W-1:0] xr, yr;

   // nearest quarter turn, residual in [-45, 45) degrees
   always_comb begin
      phase_off = phase + (PHASE_W'(1) << (PHASE_W - 3));
      quad_in   = phase_off[PHASE_W-1 -: 2];
      resid     = phase - {quad_in, {(PHASE_W-2){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad_ff[0] <= quad_in;
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= {resid[PHASE_W-1], resid};
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            quad_ff[i+1] <= quad_ff[i];
            if (!z_ff[i][CZ_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed({1'b0, ATAN_PHASE[i]});
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed({1'b0, ATAN_PHASE[i]});
            end
         end
         trig_ff <= trig_in;
      end
   end

   // round Q2.30 to Q.28, then undo the quarter turn
   always_comb begin
      xr_full = (x_ff[CORDIC_STEPS] + $signed(CX_W'(2))) >>> 2;
      yr_full = (y_ff[CORDIC_STEPS] + $signed(CX_W'(2))) >>> 2;
      xr = xr_full[TRIG_W-1:0];
      yr = yr_full[TRIG_W-1:0];
      unique case (quad_ff[CORDIC_STEPS])
         2'd0: begin trig_in.c = xr;  trig_in.s = yr;  end
         2'd1: begin trig_in.c = -yr; trig_in.s = xr;  end
         2'd2: begin trig_in.c = -xr; trig_in.s = -yr; end
         2'd3: begin trig_in.c = yr;  trig_in.s = -xr; end
      endcase
   end

   assign trig = trig_ff;

endmodule

[src/spot_test.sv]
`timescale 1ns / 1ps
// Frame rotation, separating-axis sums and final overlap decision, seven stages.
// Depends on spot_pkg; fed by the CORDIC outputs and the item line.
module spot_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  spot_pkg::item_type item,
   input  spot_pkg::trig_type trig_a,
   input  spot_pkg::trig_type trig_b,
   input  spot_pkg::trig_type trig_d,
   output logic               out_valid,
   output logic               hit
);
   import spot_pkg::*;

   logic [TEST_STAGES-1:0] v_ff;
   item_type               it_ff [TEST_STAGES];

   // stage 1: frame products and cross-term magnitudes
   logic signed [PROD_W-1:0] m_ff [8];
   logic signed [PROD_W-1:0] m_in [8];
   logic [MAG_W-1:0]         kc_ff, ks_ff, kc_in, ks_in;
   logic signed [TRIG_W-1:0] cd_abs, sd_abs;

   always_comb begin
      m_in[0] = PROD_W'(item.dx) * PROD_W'(trig_a.c);
      m_in[1] = PROD_W'(item.dy) * PROD_W'(trig_a.s);
      m_in[2] = PROD_W'(item.dx) * PROD_W'(trig_a.s);
      m_in[3] = PROD_W'(item.dy) * PROD_W'(trig_a.c);
      m_in[4] = PROD_W'(item.dx) * PROD_W'(trig_b.c);
      m_in[5] = PROD_W'(item.dy) * PROD_W'(trig_b.s);
      m_in[6] = PROD_W'(item.dx) * PROD_W'(trig_b.s);
      m_in[7] = PROD_W'(item.dy) * PROD_W'(trig_b.c);
      cd_abs  = trig_d.c[TRIG_W-1] ? -trig_d.c : trig_d.c;
      sd_abs  = trig_d.s[TRIG_W-1] ? -trig_d.s : trig_d.s;
      kc_in   = cd_abs[MAG_W-1:0];
      ks_in   = sd_abs[MAG_W-1:0];
   end

   // stage 2: frame sums and projected extents
   logic signed [FRAME_W-1:0] f_ff [4];
   logic signed [FRAME_W-1:0] f_in [4];
   logic [KP_W-1:0]           k_ff [8];
   logic [KP_W-1:0]           k_in [8];

   always_comb begin
      f_in[0] = FRAME_W'(m_ff[0]) - FRAME_W'(m_ff[1]);
      f_in[1] = FRAME_W'(m_ff[2]) + FRAME_W'(m_ff[3]);
      f_in[2] = FRAME_W'(m_ff[4]) - FRAME_W'(m_ff[5]);
      f_in[3] = FRAME_W'(m_ff[6]) + FRAME_W'(m_ff[7]);
      k_in[0] = KP_W'(kc_ff) * KP_W'(it_ff[0].bw);
      k_in[1] = KP_W'(ks_ff) * KP_W'(it_ff[0].bh);
      k_in[2] = KP_W'(ks_ff) * KP_W'(it_ff[0].bw);
      k_in[3] = KP_W'(kc_ff) * KP_W'(it_ff[0].bh);
      k_in[4] = KP_W'(kc_ff) * KP_W'(it_ff[0].aw);
      k_in[5] = KP_W'(ks_ff) * KP_W'(it_ff[0].ah);
      k_in[6] = KP_W'(ks_ff) * KP_W'(it_ff[0].aw);
      k_in[7] = KP_W'(kc_ff) * KP_W'(it_ff[0].ah);
   end

   // stage 3: rectangle frame rounded to integer Q28.0, SAT sides
   logic signed [RF_W-1:0]    rfx_ff, rfy_ff, rfx_in, rfy_in;
   logic [SAT_W-1:0]          lhs_ff [4];
   logic [SAT_W-1:0]          lhs_in [4];
   logic [SAT_W-1:0]          rhs_ff [4];
   logic [SAT_W-1:0]          rhs_in [4];
   logic signed [FRAME_W-1:0] fsx, fsy, rsx, rsy, fmag [4];
   logic                      fzero;

   always_comb begin
      if (it_ff[1].op == OP_RECT_RECT) begin
         fsx = f_ff[0]; fsy = f_ff[1]; fzero = it_ff[1].a_zero;
      end else begin
         fsx = f_ff[2]; fsy = f_ff[3]; fzero = it_ff[1].b_zero;
      end
      rsx = (fsx + HALF_LSB) >>> TRIG_FRAC;
      rsy = (fsy + HALF_LSB) >>> TRIG_FRAC;
      if (fzero) begin
         rfx_in = RF_W'(it_ff[1].dx);
         rfy_in = RF_W'(it_ff[1].dy);
      end else begin
         rfx_in = rsx[RF_W-1:0];
         rfy_in = rsy[RF_W-1:0];
      end
      for (int i = 0; i < 4; i++) begin
         fmag[i]   = f_ff[i][FRAME_W-1] ? -f_ff[i] : f_ff[i];
         lhs_in[i] = {fmag[i], 1'b0};
      end
      rhs_in[0] = SAT_W'({it_ff[1].aw, {TRIG_FRAC{1'b0}}}) + SAT_W'(k_ff[0]) + SAT_W'(k_ff[1]);
      rhs_in[1] = SAT_W'({it_ff[1].ah, {TRIG_FRAC{1'b0}}}) + SAT_W'(k_ff[2]) + SAT_W'(k_ff[3]);
      rhs_in[2] = SAT_W'({it_ff[1].bw, {TRIG_FRAC{1'b0}}}) + SAT_W'(k_ff[4]) + SAT_W'(k_ff[5]);
      rhs_in[3] = SAT_W'({it_ff[1].bh, {TRIG_FRAC{1'b0}}}) + SAT_W'(k_ff[6]) + SAT_W'(k_ff[7]);
   end

   // stage 4: axis separation, doubled magnitudes
   logic                   sep_ff, sep_in;
   logic [AX_W-1:0]        ax2_ff, ay2_ff, dax_ff, day_ff;
   logic [AX_W-1:0]        ax2_in, ay2_in, dax_in, day_in;
   logic signed [RF_W-1:0]   rxm, rym;
   logic signed [DIFF_W-1:0] dxm, dym;

   always_comb begin
      sep_in = (lhs_ff[0] > rhs_ff[0]) || (lhs_ff[1] > rhs_ff[1])
            || (lhs_ff[2] > rhs_ff[2]) || (lhs_ff[3] > rhs_ff[3]);
      rxm    = rfx_ff[RF_W-1] ? -rfx_ff : rfx_ff;
      rym    = rfy_ff[RF_W-1] ? -rfy_ff : rfy_ff;
      dxm    = it_ff[2].dx[DIFF_W-1] ? -it_ff[2].dx : it_ff[2].dx;
      dym    = it_ff[2].dy[DIFF_W-1] ? -it_ff[2].dy : it_ff[2].dy;
      ax2_in = {rxm, 1'b0};
      ay2_in = {rym, 1'b0};
      dax_in = AX_W'({dxm, 1'b0});
      day_in = AX_W'({dym, 1'b0});
   end

   // stage 5: box compares, square operand selection
   logic [AX_W-1:0]  sqa_ff, sqb_ff, sqa_in, sqb_in;
   logic [LIM_W-1:0] lim_ff, lim_in;
   logic             prh_ff, grh_ff, band_ff, rrh_ff;
   logic             prh_in, grh_in, band_in, rrh_in;

   always_comb begin
      prh_in  = (ax2_ff <= AX_W'(it_ff[3].bw)) && (ay2_ff <= AX_W'(it_ff[3].bh));
      band_in = (ax2_ff <= AX_W'(it_ff[3].bw)) || (ay2_ff <= AX_W'(it_ff[3].bh));
      grh_in  = (ax2_ff <= AX_W'(LIM_W'(it_ff[3].bw) + LIM_W'(it_ff[3].aw)))
             && (ay2_ff <= AX_W'(LIM_W'(it_ff[3].bh) + LIM_W'(it_ff[3].aw)));
      rrh_in  = it_ff[3].same_turn
             ? ((ax2_ff < AX_W'(LIM_W'(it_ff[3].aw) + LIM_W'(it_ff[3].bw)))
                && (ay2_ff < AX_W'(LIM_W'(it_ff[3].ah) + LIM_W'(it_ff[3].bh))))
             : !sep_ff;
      case (it_ff[3].op)
         OP_CIRC_RECT: begin
            // only consulted outside the side band, so both are positive there
            sqa_in = ax2_ff - AX_W'(it_ff[3].bw);
            sqb_in = ay2_ff - AX_W'(it_ff[3].bh);
            lim_in = LIM_W'(it_ff[3].aw);
         end
         OP_CIRC_CIRC: begin
            sqa_in = dax_ff;
            sqb_in = day_ff;
            lim_in = LIM_W'(it_ff[3].aw) + LIM_W'(it_ff[3].bw);
         end
         default: begin
            sqa_in = dax_ff;
            sqb_in = day_ff;
            lim_in = LIM_W'(it_ff[3].bw);
         end
      endcase
   end

   // stage 6: squares
   logic [2*AX_W-1:0]  pa2_ff, pb2_ff, pa2_in, pb2_in;
   logic [2*LIM_W-1:0] lim2_ff, lim2_in;
   logic               prh6_ff, grh6_ff, band6_ff, rrh6_ff;

   always_comb begin
      pa2_in  = (2*AX_W)'(sqa_ff) * (2*AX_W)'(sqa_ff);
      pb2_in  = (2*AX_W)'(sqb_ff) * (2*AX_W)'(sqb_ff);
      lim2_in = (2*LIM_W)'(lim_ff) * (2*LIM_W)'(lim_ff);
   end

   // stage 7: distance compare and per-kind answer
   logic hit_ff, hit_in, near;

   always_comb begin
      near = ({1'b0, pa2_ff} + {1'b0, pb2_ff}) <= (2*AX_W+1)'(lim2_ff);
      case (it_ff[5].op)
         OP_PT_CIRC, OP_CIRC_CIRC: hit_in = near;
         OP_PT_RECT:               hit_in = prh6_ff;
         OP_CIRC_RECT:             hit_in = band6_ff ? grh6_ff : near;
         OP_RECT_RECT:             hit_in = rrh6_ff;
         default:                  hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[TEST_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it_ff[0] <= item;
         for (int i = 1; i < TEST_STAGES; i++) begin
            it_ff[i] <= it_ff[i-1];
         end
         m_ff     <= m_in;
         kc_ff    <= kc_in;
         ks_ff    <= ks_in;
         f_ff     <= f_in;
         k_ff     <= k_in;
         rfx_ff   <= rfx_in;
         rfy_ff   <= rfy_in;
         lhs_ff   <= lhs_in;
         rhs_ff   <= rhs_in;
         sep_ff   <= sep_in;
         ax2_ff   <= ax2_in;
         ay2_ff   <= ay2_in;
         dax_ff   <= dax_in;
         day_ff   <= day_in;
         sqa_ff   <= sqa_in;
         sqb_ff   <= sqb_in;
         lim_ff   <= lim_in;
         prh_ff   <= prh_in;
         grh_ff   <= grh_in;
         band_ff  <= band_in;
         rrh_ff   <= rrh_in;
         pa2_ff   <= pa2_in;
         pb2_ff   <= pb2_in;
         lim2_ff  <= lim2_in;
         prh6_ff  <= prh_ff;
         grh6_ff  <= grh_ff;
         band6_ff <= band_ff;
         rrh6_ff  <= rrh_ff;
         hit_ff   <= hit_in;
      end
   end

   assign out_valid = v_ff[TEST_STAGES-1];
   assign hit       = hit_ff;

endmodule

[test/tb_shape_pair_overlap_test.sv]
`timescale 1ns / 1ps
// Testbench for shape_pair_overlap_test: random and directed shape pairs, hit flags checked
// in order against a local bit-exact predictor. Depends on spot_pkg and the block's RTL.
module tb_shape_pair_overlap_test;
   import spot_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int  LATENCY     = 43;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [OP_W-1:0]         op;
      logic signed [23:0]      a_px, a_py, b_px, b_py;
      logic [SIZE_W-1:0]       a_sx, a_sy, b_sx, b_sy;
      logic [TURN_W-1:0]       a_turn, b_turn;
   } shape_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic hit_q[$];
   int   err_count = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   recv_hold = 0;
   longint cycles = 0;

   shape_pair_overlap_test uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic logic [31:0] turn_to_phase(logic [TURN_W-1:0] t);
      longint unsigned u;
      u = longint'(t) % ANGLE_STEPS;
      return 32'((u << 32) / ANGLE_STEPS);
   endfunction

   task automatic cordic_trig(input logic [31:0] ph, output longint c, output longint s);
      logic [1:0]  q;
      logic [31:0] r;
      longint x, y, z, nx;
      q = 2'((ph + 32'h20000000) >> 30);
      r = ph - {q, 30'b0};
      z = longint'($signed(r));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_PHASE[i]);
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_PHASE[i]);
         end
         x = nx;
      end
      x = (x + 2) >>> 2;
      y = (y + 2) >>> 2;
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   function automatic longint magn(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic sq_sum_within(longint a, longint b, longint lim);
      logic [127:0] sum;
      sum = 128'(a) * 128'(a) + 128'(b) * 128'(b);
      return sum <= 128'(lim);
   endfunction

   // offset rotated into a rectangle's frame, rounded back to integer Q28.0
   task automatic into_rect_frame(input longint dx, input longint dy, input logic [31:0] ph,
                                  output longint fx, output longint fy);
      longint c, s;
      if (ph == 0) begin
         fx = dx; fy = dy;
      end else begin
         cordic_trig(ph, c, s);
         fx = (dx * c - dy * s + (longint'(1) << 27)) >>> 28;
         fy = (dx * s + dy * c + (longint'(1) << 27)) >>> 28;
      end
   endtask

   task automatic predict_hit(input shape_pair_type p, output logic hit);
      longint dx, dy, aw, ah, bw, bh, fx, fy, gx, gy, ax2, ay2;
      longint ca, sa, cb, sb, cd, sd, kc, ks;
      logic [31:0] pa, pb;
      dx = longint'(p.a_px) - longint'(p.b_px);
      dy = longint'(p.a_py) - longint'(p.b_py);
      aw = p.a_sx; ah = p.a_sy; bw = p.b_sx; bh = p.b_sy;
      pa = turn_to_phase(p.a_turn);
      pb = turn_to_phase(p.b_turn);
      hit = 1'b0;
      case (p.op)
         OP_PT_CIRC:   hit = sq_sum_within(2 * magn(dx), 2 * magn(dy), bw * bw);
         OP_CIRC_CIRC: hit = sq_sum_within(2 * magn(dx), 2 * magn(dy), (aw + bw) * (aw + bw));
         OP_PT_RECT: begin
            into_rect_frame(dx, dy, pb, fx, fy);
            hit = 2 * magn(fx) <= bw && 2 * magn(fy) <= bh;
         end
         OP_CIRC_RECT: begin
            into_rect_frame(dx, dy, pb, fx, fy);
            ax2 = 2 * magn(fx);
            ay2 = 2 * magn(fy);
            if (ax2 <= bw || ay2 <= bh)
               hit = ax2 <= bw + aw && ay2 <= bh + aw;
            else
               hit = sq_sum_within(ax2 - bw, ay2 - bh, aw * aw);
         end
         OP_RECT_RECT: begin
            if (pa == pb) begin
               into_rect_frame(dx, dy, pa, fx, fy);
               hit = 2 * magn(fx) < aw + bw && 2 * magn(fy) < ah + bh;
            end else begin
               cordic_trig(pa, ca, sa);
               cordic_trig(pb, cb, sb);
               cordic_trig(pa - pb, cd, sd);
               kc = magn(cd); ks = magn(sd);
               fx = dx * ca - dy * sa; fy = dx * sa + dy * ca;
               gx = dx * cb - dy * sb; gy = dx * sb + dy * cb;
               hit = !(2 * magn(fx) > (aw << 28) + kc * bw + ks * bh ||
                       2 * magn(fy) > (ah << 28) + ks * bw + kc * bh ||
                       2 * magn(gx) > (bw << 28) + kc * aw + ks * ah ||
                       2 * magn(gy) > (bh << 28) + ks * aw + kc * ah);
            end
         end
         default: hit = 1'b0;
      endcase
   endtask

   // ---------------- stimulus ----------------
   task automatic send_pair(input shape_pair_type p);
      logic hit;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata <= REQ_DATA_W'({p.b_turn, p.b_sy, p.b_sx, p.b_py, p.b_px,
                                p.a_turn, p.a_sy, p.a_sx, p.a_py, p.a_px});
      req_tuser  <= p.op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_hit(p, hit);
      hit_q.push_back(hit);
   endtask

   function automatic logic [SIZE_W-1:0] rand_size();
      case ($urandom_range(7))
         0: return SIZE_W'($urandom);
         1: return '0;
         default: return SIZE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [TURN_W-1:0] rand_turn();
      case ($urandom_range(5))
         0: return '0;
         1: return TURN_W'($urandom);   // may exceed a full turn
         default: return TURN_W'($urandom_range(0, ANGLE_STEPS - 1));
      endcase
   endfunction

   function automatic shape_pair_type rand_pair();
      shape_pair_type p;
      longint r, off_x, off_y;
      p.op = ($urandom_range(19) == 0) ? OP_W'($urandom) : OP_W'($urandom_range(0, 4));
      p.a_sx = rand_size(); p.a_sy = rand_size();
      p.b_sx = rand_size(); p.b_sy = rand_size();
      p.a_turn = rand_turn();
      p.b_turn = ($urandom_range(3) == 0) ? p.a_turn : rand_turn();
      if ($urandom_range(9) == 0) begin
         p.a_px = 24'($urandom); p.a_py = 24'($urandom);
         p.b_px = 24'($urandom); p.b_py = 24'($urandom);
      end else begin
         // keep the shapes near each other so both answers turn up
         r = longint'(p.a_sx) + p.b_sx + p.b_sy + 256;
         if (r > (1 << 22) - 1) r = (1 << 22) - 1;
         off_x = longint'($urandom_range(0, 32'(2 * r))) - r;
         off_y = longint'($urandom_range(0, 32'(2 * r))) - r;
         p.b_px = 24'(longint'($urandom_range(0, 1 << 23)) - (1 << 22));
         p.b_py = 24'(longint'($urandom_range(0, 1 << 23)) - (1 << 22));
         p.a_px = 24'(longint'(p.b_px) + off_x);
         p.a_py = 24'(longint'(p.b_py) + off_y);
      end
      return p;
   endfunction

   function automatic shape_pair_type make_pair(logic [OP_W-1:0] op,
                                             longint ax, longint ay, longint asx, longint asy,
                                             longint at, longint bx, longint by, longint bsx,
                                             longint bsy, longint bt);
      shape_pair_type p;
      p.op = op;
      p.a_px = 24'(ax); p.a_py = 24'(ay); p.a_sx = SIZE_W'(asx); p.a_sy = SIZE_W'(asy);
      p.a_turn = TURN_W'(at);
      p.b_px = 24'(bx); p.b_py = 24'(by); p.b_sx = SIZE_W'(bsx); p.b_sy = SIZE_W'(bsy);
      p.b_turn = TURN_W'(bt);
      return p;
   endfunction

   task automatic test_directed();
      longint mx, mn, sm;
      mx = 8388607; mn = -8388608; sm = 8388607;
      // touching boundaries, extreme coordinates and turned rectangles
      send_pair(make_pair(OP_PT_CIRC, 50, 0, 0, 0, 0, 0, 0, 100, 0, 0));
      send_pair(make_pair(OP_PT_CIRC, 51, 0, 0, 0, 0, 0, 0, 100, 0, 0));
      send_pair(make_pair(OP_CIRC_CIRC, 100, 0, 100, 0, 0, 0, 0, 100, 0, 0));
      send_pair(make_pair(OP_CIRC_CIRC, mx, mx, sm, 0, 0, mn, mn, sm, 0, 0));
      send_pair(make_pair(OP_PT_RECT, 100, 50, 0, 0, 0, 0, 0, 200, 100, 0));
      send_pair(make_pair(OP_PT_RECT, 100, 50, 0, 0, 0, 0, 0, 200, 100, 720));
      send_pair(make_pair(OP_PT_RECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8191));
      // circle against rectangle: side band, corner, far
      send_pair(make_pair(OP_CIRC_RECT, 150, 0, 100, 0, 0, 0, 0, 200, 100, 0));
      send_pair(make_pair(OP_CIRC_RECT, 130, 80, 100, 0, 0, 0, 0, 200, 100, 0));
      send_pair(make_pair(OP_CIRC_RECT, 140, 90, 100, 0, 0, 0, 0, 200, 100, 1440));
      send_pair(make_pair(OP_CIRC_RECT, mn, mx, sm, 0, 0, mx, mn, sm, sm, 5759));
      // rectangle pairs: equal angles strict, equal modulo a full turn, unequal
      send_pair(make_pair(OP_RECT_RECT, 200, 0, 200, 100, 0, 0, 0, 200, 100, 0));
      send_pair(make_pair(OP_RECT_RECT, 199, 0, 200, 100, 0, 0, 0, 200, 100, 0));
      send_pair(make_pair(OP_RECT_RECT, 100, 30, 200, 100, 5760, 0, 0, 200, 100, 0));
      send_pair(make_pair(OP_RECT_RECT, 250, 0, 200, 100, 720, 0, 0, 200, 100, 0));
      send_pair(make_pair(OP_RECT_RECT, 300, 300, 200, 100, 100, 0, 0, 200, 100, 4000));
      send_pair(make_pair(OP_RECT_RECT, mx, mx, sm, sm, 8191, mn, mn, sm, sm, 1));
      send_pair(make_pair(OP_RECT_RECT, mn, mn, sm, sm, 2880, mx, mx, sm, sm, 5759));
      // unused kinds
      send_pair(make_pair(OP_SPARE_5, 0, 0, 100, 100, 0, 0, 0, 100, 100, 0));
      send_pair(make_pair(OP_SPARE_6, 0, 0, sm, sm, 0, 0, 0, sm, sm, 0));
      send_pair(make_pair(OP_SPARE_7, mx, mn, sm, sm, 8191, mn, mx, sm, sm, 8191));
   endtask

   task automatic test_random(input int n, input int s_idle, input int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      repeat (n) send_pair(rand_pair());
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 300;
      repeat (80) send_pair(rand_pair());
   endtask

   // ---------------- receiver and checker ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold > 0) begin
         rsp_tready <= 1'b0;
         recv_hold  <= recv_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_q.size() == 0) begin
            $error("unexpected item: hit actual %0d", rsp_tdata[0]);
            err_count++;
         end else begin
            logic want;
            want = hit_q.pop_front();
            if (rsp_tdata[0] !== want) begin
               $error("hit mismatch: expected %0d actual %0d", want, rsp_tdata[0]);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_shape_pair_overlap_test NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(270, 15, 75);
      test_random(270, 75, 15);
      test_random(270, 0, 0);
      test_backpressure();
      req_tvalid <= 1'b0;
      recv_idle_pct = 0;
      while (hit_q.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (err_count == 0)
         $display("tb_shape_pair_overlap_test OK");
      else
         $display("tb_shape_pair_overlap_test NOT OK");
      $finish;
   end

endmodule

[shape_pair_overlap_test.f]
src/spot_pkg.sv
src/spot_phase.sv
src/spot_cordic.sv
src/spot_test.sv
src/shape_pair_overlap_test.sv
test/tb_shape_pair_overlap_test.sv
